@@ rtl/tcpc_pkg.sv @@
// shared types, constants and codes for the text console put-char unit
// no dependencies
`default_nettype none

package tcpc_pkg;

	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int CELLS    = ROWS * COLUMNS;
	localparam int SCR_LEN  = (ROWS - 1) * COLUMNS;
	localparam int TAB_STOP = 8;

	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS + TAB_STOP);
	localparam int ROW_W  = $clog2(ROWS + 1);
	localparam int OUT_W  = 11;

	localparam logic [7:0] RESET_ATTR = 8'h0F;
	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] CH_BS      = 8'h08;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;

	localparam logic KIND_PUT   = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// store operation codes
	localparam logic [1:0] ST_WRITE  = 2'd0;
	localparam logic [1:0] ST_SCROLL = 2'd1;
	localparam logic [1:0] ST_FILL   = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] character;
	} put_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] cursor_position;
		logic             cell_written;
		logic [OUT_W-1:0] cell_address;
		logic [15:0]      cell_value;
		logic             scrolled;
	} result_t;

	typedef struct packed {
		logic              valid;
		logic [1:0]        op;
		logic [ADDR_W-1:0] addr;
		logic [15:0]       data;
	} store_cmd_t;

endpackage

`default_nettype wire

@@ rtl/tcpc_store.sv @@
// cell store: 2-d character memory with write, scroll-up and fill sweeps
// depends on tcpc_pkg
`default_nettype none

module tcpc_store
	import tcpc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire store_cmd_t cmd,
	output logic            store_busy
);

	localparam logic [1:0] M_IDLE   = 2'd0;
	localparam logic [1:0] M_SCROLL = 2'd1;
	localparam logic [1:0] M_FILL   = 2'd2;

	logic [15:0]       mem [CELLS];
	logic [1:0]        mode_q;
	logic [ADDR_W-1:0] wr_ptr_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic              rd_more_q;
	logic              cp_valid_q;
	logic [15:0]       rd_data_q;
	logic [15:0]       blank_q;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [15:0]       wdata;
	logic              re;

	assign store_busy = (mode_q != M_IDLE);

	always_comb begin
		we    = 1'b0;
		waddr = wr_ptr_q;
		wdata = blank_q;
		re    = 1'b0;
		case (mode_q)
			M_IDLE: begin
				if (cmd.valid && cmd.op == ST_WRITE) begin
					we    = 1'b1;
					waddr = cmd.addr;
					wdata = cmd.data;
				end
			end
			M_SCROLL: begin
				re = rd_more_q;
				if (cp_valid_q) begin
					we    = 1'b1;
					wdata = rd_data_q;
				end
			end
			M_FILL: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_FILL;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			rd_more_q  <= 1'b0;
			cp_valid_q <= 1'b0;
			blank_q    <= {RESET_ATTR, BLANK_CHAR};
		end else begin
			case (mode_q)
				M_IDLE: begin
					if (cmd.valid && cmd.op == ST_SCROLL) begin
						mode_q     <= M_SCROLL;
						wr_ptr_q   <= '0;
						rd_ptr_q   <= ADDR_W'(COLUMNS);
						rd_more_q  <= 1'b1;
						cp_valid_q <= 1'b0;
						blank_q    <= cmd.data;
					end else if (cmd.valid && cmd.op == ST_FILL) begin
						mode_q   <= M_FILL;
						wr_ptr_q <= '0;
						blank_q  <= cmd.data;
					end
				end
				M_SCROLL: begin
					cp_valid_q <= rd_more_q;
					if (rd_more_q) begin
						if (rd_ptr_q == ADDR_W'(CELLS - 1)) begin
							rd_more_q <= 1'b0;
						end else begin
							rd_ptr_q <= rd_ptr_q + 1'b1;
						end
					end
					if (cp_valid_q) begin
						wr_ptr_q <= wr_ptr_q + 1'b1;
						if (!rd_more_q) begin
							mode_q <= M_FILL;
						end
					end
				end
				M_FILL: begin
					if (wr_ptr_q == ADDR_W'(CELLS - 1)) begin
						mode_q <= M_IDLE;
					end else begin
						wr_ptr_q <= wr_ptr_q + 1'b1;
					end
				end
				default: begin
					mode_q <= M_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/text_console_put_char_unit.sv @@
// text console put-char unit: cursor sequencer, attribute register, result output
// depends on tcpc_pkg and tcpc_store
// printable or control byte without scroll: item passes the decode, wrap and report states, strobe registered in report
// scroll adds a store sweep (one cell copied or blanked per store cycle)
// clear item waits for a fill sweep over all cells; the strobe cannot be held off
// after reset the store is blanked by a fill sweep with busy high
`default_nettype none

module text_console_put_char_unit
	import tcpc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data,
	input  wire logic       start,
	output logic            busy,
	input  wire put_item_t  item,
	output logic            done,
	output result_t         result
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_WRAP   = 3'd2;
	localparam logic [2:0] S_WAIT   = 3'd3;
	localparam logic [2:0] S_REPORT = 3'd4;

	logic [2:0]       state_q;
	put_item_t        item_q;
	logic [7:0]       attr_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             done_q;
	result_t          result_q;

	store_cmd_t        cmd;
	logic              store_busy;
	logic [15:0]       blank;
	logic [ADDR_W-1:0] lin_pos;
	logic              printable;
	logic [COL_W-1:0]  col_n;
	logic [ROW_W-1:0]  row_n;
	logic [COL_W-1:0]  tab_sum;
	logic              wrap;
	logic [ROW_W-1:0]  row_w;
	logic              scroll;

	tcpc_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.store_busy (store_busy)
	);

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != S_IDLE) || store_busy;
	assign done      = done_q;
	assign result    = result_q;
	assign blank     = {attr_q, BLANK_CHAR};
	assign lin_pos   = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);

	assign printable = (item_q.character != CH_BS) && (item_q.character != CH_TAB)
		&& (item_q.character != CH_CR) && (item_q.character != CH_LF);

	assign tab_sum = col_q + COL_W'(TAB_STOP);

	always_comb begin
		col_n = col_q;
		row_n = row_q;
		case (item_q.character)
			CH_BS: begin
				if (col_q != '0) begin
					col_n = col_q - 1'b1;
				end
			end
			CH_TAB: begin
				col_n = tab_sum & ~COL_W'(TAB_STOP - 1);
			end
			CH_CR: begin
				col_n = '0;
			end
			CH_LF: begin
				col_n = '0;
				row_n = row_q + 1'b1;
			end
			default: begin
				col_n = col_q + 1'b1;
			end
		endcase
	end

	assign wrap   = (col_q >= COL_W'(COLUMNS));
	assign row_w  = wrap ? row_q + 1'b1 : row_q;
	assign scroll = (row_w >= ROW_W'(ROWS));

	always_comb begin
		cmd       = '0;
		cmd.addr  = lin_pos;
		cmd.data  = blank;
		case (state_q)
			S_DECODE: begin
				if (item_q.kind == KIND_CLEAR) begin
					cmd.valid = 1'b1;
					cmd.op    = ST_FILL;
				end else if (printable) begin
					cmd.valid = 1'b1;
					cmd.op    = ST_WRITE;
					cmd.data  = {attr_q, item_q.character};
				end
			end
			S_WRAP: begin
				if (scroll) begin
					cmd.valid = 1'b1;
					cmd.op    = ST_SCROLL;
				end
			end
			default: begin
				cmd.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (cfg_valid && cfg_ready) begin
			attr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			item_q   <= '0;
			col_q    <= '0;
			row_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start && !busy) begin
						item_q  <= item;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					result_q.scrolled <= 1'b0;
					if (item_q.kind == KIND_CLEAR) begin
						col_q                 <= '0;
						row_q                 <= '0;
						result_q.cell_written <= 1'b0;
						result_q.cell_address <= '0;
						result_q.cell_value   <= '0;
						state_q               <= S_WAIT;
					end else begin
						col_q                 <= col_n;
						row_q                 <= row_n;
						result_q.cell_written <= printable;
						result_q.cell_address <= printable ? OUT_W'(lin_pos) : '0;
						result_q.cell_value   <= printable ? {attr_q, item_q.character} : '0;
						state_q               <= S_WRAP;
					end
				end
				S_WRAP: begin
					if (wrap) begin
						col_q <= '0;
					end
					row_q             <= scroll ? ROW_W'(ROWS - 1) : row_w;
					result_q.scrolled <= scroll;
					state_q           <= scroll ? S_WAIT : S_REPORT;
				end
				S_WAIT: begin
					if (!store_busy) begin
						state_q <= S_REPORT;
					end
				end
				S_REPORT: begin
					result_q.cursor_position <= OUT_W'(lin_pos);
					done_q                   <= 1'b1;
					state_q                  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// strobe only follows the report step
	a_done_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_REPORT)
		else $error("result strobe without report step");

	// accepted item keeps the unit busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("not busy after accept");

	// cursor inside the screen between items
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (row_q < ROW_W'(ROWS)) && (col_q < COL_W'(COLUMNS)))
		else $error("cursor outside screen while idle");

endmodule

`default_nettype wire
